/* rtl/core/lftm_pkg.sv */
package lftm_pkg;

	localparam logic [2:0] OP_LOOP_START = 3'd0;
	localparam logic [2:0] OP_LOOP_END   = 3'd1;
	localparam logic [2:0] OP_RECORD     = 3'd2;
	localparam logic [2:0] OP_TOTALS     = 3'd3;
	localparam logic [2:0] OP_FEATURE    = 3'd4;
	localparam logic [2:0] OP_RESET      = 3'd5;

	localparam logic [1:0] DIV_AVG   = 2'd0;
	localparam logic [1:0] DIV_LOOP  = 2'd1;
	localparam logic [1:0] DIV_USAGE = 2'd2;

	localparam logic [31:0] WINDOW_RESET = 32'd1000000;
	localparam logic [9:0]  USAGE_SCALE  = 10'd1000;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] timestamp_us;
		logic [15:0] feature_key;
		logic [31:0] duration_us;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [31:0] min_us;
		logic [31:0] avg_us;
		logic [31:0] max_us;
		logic [31:0] busy_total_us;
		logic [31:0] idle_total_us;
		logic [31:0] loop_total;
		logic [31:0] avg_loop_us;
		logic [9:0]  usage_tenths;
		logic        rolled;
	} result_t;

	typedef struct packed {
		logic       load;
		logic       exec;
		logic       scan_init;
		logic       scan_next;
		logic       prev;
		logic       rd;
		logic       wr_hit;
		logic       wr_new;
		logic       cap;
		logic       div_start;
		logic       div_take;
		logic [1:0] div_sel;
	} cmd_t;

	typedef struct packed {
		logic is_rec;
		logic scan_end;
		logic key_eq;
		logic cnt_nz;
		logic full;
		logic div_done;
	} status_t;

endpackage

/* rtl/core/lftm_div.sv */
module lftm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] sh;
	logic [32:0] diff;
	logic        ge;

	assign sh   = {rem_q, quo_q[63]};
	assign ge   = sh >= {1'b0, den_q};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : sh[31:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

/* rtl/core/lftm_datapath.sv */
module lftm_datapath #(
	parameter int TABLE_ENTRIES = 32,
	parameter int KEY_BITS      = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lftm_pkg::item_t   item,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_data,
	input  lftm_pkg::cmd_t    cmd,
	output lftm_pkg::status_t st,
	output lftm_pkg::result_t result
);
	import lftm_pkg::*;

	localparam int AW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int UW      = $clog2(TABLE_ENTRIES + 1);
	localparam int CNT_LSB = 0;
	localparam int SUM_LSB = 32;
	localparam int MAX_LSB = 96;
	localparam int MIN_LSB = 128;
	localparam int KEY_LSB = 160;
	localparam int EW      = KEY_LSB + KEY_BITS;
	localparam logic [UW-1:0] FULL = UW'(TABLE_ENTRIES);

	item_t         item_q;
	logic [31:0]   window_q;
	logic          started_q, in_loop_q, bank_q, rolled_q;
	logic [31:0]   lstart_q, lend_q, wstart_q;
	logic [31:0]   busy_q, idle_q, loops_q, pbusy_q, pidle_q, ploops_q;
	logic [UW-1:0] cur_used_q, prev_used_q, idx_q;
	logic [EW-1:0] mem [2**(AW+1)];
	logic [EW-1:0] rd_q;
	logic [EW-1:0] wdata;
	logic [AW:0]   addr;
	logic          found_q;
	logic [31:0]   fmin_q, fmax_q, favg_q, avgl_q, cnt_cap_q;
	logic [63:0]   sum_cap_q;
	logic [9:0]    usage_q;
	logic          div_zero_q;
	logic [63:0]   dividend;
	logic [31:0]   divisor;
	logic [63:0]   quotient;
	logic          div_done;
	logic [31:0]   key_ext;
	logic [KEY_BITS-1:0] key;
	logic [31:0]   now, dur, les, busy_new, loops_new;
	logic [31:0]   busy_sel, idle_sel, loops_sel, ub, ui, ptotal, total;
	logic [31:0]   r_cnt, r_min, r_max;
	logic [63:0]   r_sum;

	assign key_ext = {16'b0, item_q.feature_key};
	assign key     = key_ext[KEY_BITS-1:0];
	assign now     = item_q.timestamp_us;
	assign dur     = item_q.duration_us;
	assign les     = started_q ? lend_q : now;
	assign busy_new  = busy_q + (now - lstart_q);
	assign loops_new = loops_q + 32'd1;

	assign busy_sel  = (pbusy_q != 0) ? pbusy_q : busy_q;
	assign idle_sel  = (pidle_q != 0) ? pidle_q : idle_q;
	assign loops_sel = (ploops_q != 0) ? ploops_q : loops_q;
	assign ptotal    = pbusy_q + pidle_q;
	assign ub        = (ptotal != 0) ? pbusy_q : busy_q;
	assign ui        = (ptotal != 0) ? pidle_q : idle_q;
	assign total     = ub + ui;

	assign r_cnt = rd_q[CNT_LSB +: 32];
	assign r_sum = rd_q[SUM_LSB +: 64];
	assign r_max = rd_q[MAX_LSB +: 32];
	assign r_min = rd_q[MIN_LSB +: 32];

	assign addr = {cmd.prev ? ~bank_q : bank_q, idx_q[AW-1:0]};

	always_comb begin
		wdata = {key, dur, dur, {32'b0, dur}, 32'd1};
		if (cmd.wr_hit && r_cnt != 0) begin
			wdata = {key, (dur < r_min) ? dur : r_min, (dur > r_max) ? dur : r_max,
				r_sum + {32'b0, dur}, r_cnt + 32'd1};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_hit || cmd.wr_new) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			started_q   <= 1'b0;
			in_loop_q   <= 1'b0;
			bank_q      <= 1'b0;
			rolled_q    <= 1'b0;
			lstart_q    <= '0;
			lend_q      <= '0;
			wstart_q    <= '0;
			busy_q      <= '0;
			idle_q      <= '0;
			loops_q     <= '0;
			pbusy_q     <= '0;
			pidle_q     <= '0;
			ploops_q    <= '0;
			cur_used_q  <= '0;
			prev_used_q <= '0;
			idx_q       <= '0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_data;
			end
			if (cmd.load) begin
				rolled_q <= 1'b0;
			end
			if (cmd.scan_init) begin
				idx_q <= '0;
			end else if (cmd.scan_next) begin
				idx_q <= idx_q + UW'(1);
			end
			if (cmd.wr_new) begin
				cur_used_q <= cur_used_q + UW'(1);
			end
			if (cmd.exec) begin
				case (item_q.opcode)
					OP_LOOP_START: begin
						started_q <= 1'b1;
						if (!started_q) begin
							wstart_q <= now;
						end
						lend_q <= les;
						if (les != 0) begin
							idle_q <= idle_q + (now - les);
						end
						lstart_q  <= now;
						in_loop_q <= 1'b1;
					end
					OP_LOOP_END: begin
						if (in_loop_q) begin
							lend_q    <= now;
							in_loop_q <= 1'b0;
							if (now - wstart_q >= window_q) begin
								pbusy_q     <= busy_new;
								pidle_q     <= idle_q;
								ploops_q    <= loops_new;
								prev_used_q <= cur_used_q;
								cur_used_q  <= '0;
								busy_q      <= '0;
								idle_q      <= '0;
								loops_q     <= '0;
								wstart_q    <= now;
								bank_q      <= ~bank_q;
								rolled_q    <= 1'b1;
							end else begin
								busy_q  <= busy_new;
								loops_q <= loops_new;
							end
						end
					end
					OP_RESET: begin
						busy_q    <= '0;
						idle_q    <= '0;
						loops_q   <= '0;
						pbusy_q   <= '0;
						pidle_q   <= '0;
						ploops_q  <= '0;
						wstart_q  <= now;
						lend_q    <= now;
						in_loop_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			found_q <= 1'b0;
			fmin_q  <= '0;
			fmax_q  <= '0;
		end else if (cmd.cap) begin
			found_q   <= 1'b1;
			fmin_q    <= r_min;
			fmax_q    <= r_max;
			sum_cap_q <= r_sum;
			cnt_cap_q <= r_cnt;
		end
		if (cmd.div_start) begin
			case (cmd.div_sel)
				DIV_AVG:  div_zero_q <= !found_q;
				DIV_LOOP: div_zero_q <= loops_sel == 0;
				default:  div_zero_q <= total == 0;
			endcase
		end
		if (cmd.div_take) begin
			case (cmd.div_sel)
				DIV_AVG:  favg_q <= div_zero_q ? 32'd0 : quotient[31:0];
				DIV_LOOP: avgl_q <= div_zero_q ? 32'd0 : quotient[31:0];
				default: begin
					if (div_zero_q) begin
						usage_q <= '0;
					end else if (quotient > {54'b0, USAGE_SCALE}) begin
						usage_q <= USAGE_SCALE;
					end else begin
						usage_q <= quotient[9:0];
					end
				end
			endcase
		end
	end

	always_comb begin
		case (cmd.div_sel)
			DIV_AVG: begin
				dividend = sum_cap_q;
				divisor  = cnt_cap_q;
			end
			DIV_LOOP: begin
				dividend = {32'b0, busy_sel};
				divisor  = loops_sel;
			end
			default: begin
				dividend = {32'b0, ub} * {54'b0, USAGE_SCALE};
				divisor  = total;
			end
		endcase
	end

	lftm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	assign st.is_rec   = item_q.opcode == OP_RECORD;
	assign st.scan_end = idx_q == (cmd.prev ? prev_used_q : cur_used_q);
	assign st.key_eq   = rd_q[KEY_LSB +: KEY_BITS] == key;
	assign st.cnt_nz   = r_cnt != 0;
	assign st.full     = cur_used_q == FULL;
	assign st.div_done = div_done;

	assign result.found         = found_q;
	assign result.min_us        = fmin_q;
	assign result.avg_us        = favg_q;
	assign result.max_us        = fmax_q;
	assign result.busy_total_us = busy_sel;
	assign result.idle_total_us = idle_sel;
	assign result.loop_total    = loops_sel;
	assign result.avg_loop_us   = avgl_q;
	assign result.usage_tenths  = usage_q;
	assign result.rolled        = rolled_q;
endmodule

/* rtl/core/lftm_ctrl.sv */
module lftm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lftm_pkg::status_t st,
	output lftm_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);
	import lftm_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EXEC = 4'd1;
	localparam logic [3:0] S_RREQ = 4'd2;
	localparam logic [3:0] S_RCMP = 4'd3;
	localparam logic [3:0] S_LREQ = 4'd4;
	localparam logic [3:0] S_LCMP = 4'd5;
	localparam logic [3:0] S_DS   = 4'd6;
	localparam logic [3:0] S_DW   = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0] state_q, state_d;
	logic [1:0] div_k_q;

	always_comb begin
		cmd         = '0;
		cmd.div_sel = div_k_q;
		state_d     = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec      = 1'b1;
				cmd.scan_init = 1'b1;
				state_d       = st.is_rec ? S_RREQ : S_LREQ;
			end
			S_RREQ: begin
				if (st.scan_end) begin
					cmd.wr_new    = !st.full;
					cmd.scan_init = 1'b1;
					state_d       = S_LREQ;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_RCMP;
				end
			end
			S_RCMP: begin
				if (st.key_eq) begin
					cmd.wr_hit    = 1'b1;
					cmd.scan_init = 1'b1;
					state_d       = S_LREQ;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_RREQ;
				end
			end
			S_LREQ: begin
				cmd.prev = 1'b1;
				if (st.scan_end) begin
					state_d = S_DS;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_LCMP;
				end
			end
			S_LCMP: begin
				cmd.prev = 1'b1;
				if (st.key_eq && st.cnt_nz) begin
					cmd.cap = 1'b1;
					state_d = S_DS;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_LREQ;
				end
			end
			S_DS: begin
				cmd.div_start = 1'b1;
				state_d       = S_DW;
			end
			S_DW: begin
				if (st.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = (div_k_q == DIV_USAGE) ? S_DONE : S_DS;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_k_q <= DIV_AVG;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				div_k_q <= DIV_AVG;
			end else if (cmd.div_take) begin
				div_k_q <= div_k_q + 2'd1;
			end
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transfer did not raise busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_take_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.div_take) && $past(div_k_q) == DIV_USAGE)
		else $error("result issued before the last division");
	a_no_wr_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prev |-> !(cmd.wr_hit || cmd.wr_new)) else $error("write into last-window bank");
endmodule

/* rtl/core/loop_and_feature_time_monitor_core.sv */
// One event is taken when start is high and busy is low; its result appears for exactly one
// cycle with done high and must be captured then, since the receiver cannot stall the block.
// An event passes from its accepting cycle to its result cycle through a record scan of the
// current-window entries (bounded by the filled entries, and only for a record), a lookup scan
// of the last-window entries and then the three divisions; each scan stops at a match or at the
// end of the filled entries, and each entry is read in one state and compared in the next. The
// feature table has one memory port and the three divisions share one 64-step restoring divider.
module loop_and_feature_time_monitor_core #(
	parameter int TABLE_ENTRIES = 32,
	parameter int KEY_BITS      = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lftm_pkg::item_t   item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data,
	output logic              done,
	output lftm_pkg::result_t result
);
	import lftm_pkg::*;

	cmd_t    cmd;
	status_t st;

	assign cfg_ready = !busy;

	lftm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	lftm_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KEY_BITS      (KEY_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.st       (st),
		.result   (result)
	);
endmodule
